[design/tfn_pkg.sv]
// Shared types and constants for the triangle face normal pipeline.
// No dependencies; the cells and the top level take names from here.
package tfn_pkg;

  localparam int NumAxes   = 3;
  localparam int ShiftSteps = 6;
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 32;

  // Request: three vertices in signed Q16.16
  typedef struct packed {
    logic signed [31:0] vertex_a_x;
    logic signed [31:0] vertex_a_y;
    logic signed [31:0] vertex_a_z;
    logic signed [31:0] vertex_b_x;
    logic signed [31:0] vertex_b_y;
    logic signed [31:0] vertex_b_z;
    logic signed [31:0] vertex_c_x;
    logic signed [31:0] vertex_c_y;
    logic signed [31:0] vertex_c_z;
  } face_t;

  // Result: unit normal in signed Q1.30 plus degenerate flag
  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic               degenerate;
  } normal_t;

  // Control carried alongside each square root and division stage
  typedef struct packed {
    logic       vld;
    logic       degen;
    logic [2:0] neg;
  } tag_t;

  // One step of the square root chain: two radicand bits per cell
  typedef struct packed {
    tag_t             tag;
    logic [2:0][30:0] m;
    logic [33:0]      rem;
    logic [31:0]      root;
    logic [63:0]      rad;
  } sqrt_stage_t;

  // One step of the division chain: one quotient bit per cell, three lanes
  typedef struct packed {
    tag_t             tag;
    logic [31:0]      len;
    logic [2:0][31:0] rem;
    logic [2:0][31:0] quo;
  } div_stage_t;

endpackage

[design/triangle_face_normal.sv]
// Triangle unit face normal: top level of the pipeline.
// Depends on tfn_pkg, tfn_sqrt_cell and tfn_div_cell.
//
// Usage:
//   face channel (face_valid / face_ready / face) takes one triangle per
//   request: three vertices in signed Q16.16.
//   normal channel (normal_valid / normal_ready / normal) returns one
//   result per request: the unit normal in signed Q1.30 and a degenerate
//   flag, set with a zero normal when the cross product is zero.
// Throughput: one request per cycle while the output does not stall. The
//   pipeline is 77 register stages: edges, products, cross product,
//   magnitude, six pre-scale shift cells, squares, sum, 32 square root
//   cells, 32 division cells and the output register.
// Stall: while a result waits with normal_ready low, every stage holds and
//   face_ready is low; the output register holds the result unchanged.
// Reset: rst clears every stage's valid flag; no state survives between
//   requests, so the block is ready in the first cycle after reset.
module triangle_face_normal (
  input  logic             clk,
  input  logic             rst,
  input  logic             face_valid,
  output logic             face_ready,
  input  tfn_pkg::face_t   face,
  output logic             normal_valid,
  input  logic             normal_ready,
  output tfn_pkg::normal_t normal
);

  logic adv;

  logic               s1_vld;
  logic signed [32:0] s1_e1 [3];
  logic signed [32:0] s1_e2 [3];
  logic               s2_vld;
  logic signed [65:0] s2_p [6];
  logic               s3_vld;
  logic signed [65:0] s3_n [3];
  logic signed [65:0] abs_n [3];

  logic        sh_vld [7];
  logic        sh_dgn [7];
  logic [2:0]  sh_neg [7];
  logic [64:0] sh_mag [7][3];

  logic             sq_vld;
  logic             sq_dgn;
  logic [2:0]       sq_neg;
  logic [2:0][30:0] sq_m;
  logic [61:0]      sq_v [3];

  tfn_pkg::sqrt_stage_t sqc [tfn_pkg::SqrtSteps + 1];
  tfn_pkg::div_stage_t  dvc [tfn_pkg::DivSteps + 1];
  tfn_pkg::div_stage_t  dv_last;
  logic [2:0][31:0]     res;
  logic [32:0]          rnd [3];

  // Advance the whole pipe whenever the output register is free
  assign adv        = !normal_valid || normal_ready;
  assign face_ready = adv;

  // Edge vectors B-A and C-A
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= face_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_e1[0] <= {face.vertex_b_x[31], face.vertex_b_x} - {face.vertex_a_x[31], face.vertex_a_x};
      s1_e1[1] <= {face.vertex_b_y[31], face.vertex_b_y} - {face.vertex_a_y[31], face.vertex_a_y};
      s1_e1[2] <= {face.vertex_b_z[31], face.vertex_b_z} - {face.vertex_a_z[31], face.vertex_a_z};
      s1_e2[0] <= {face.vertex_c_x[31], face.vertex_c_x} - {face.vertex_a_x[31], face.vertex_a_x};
      s1_e2[1] <= {face.vertex_c_y[31], face.vertex_c_y} - {face.vertex_a_y[31], face.vertex_a_y};
      s1_e2[2] <= {face.vertex_c_z[31], face.vertex_c_z} - {face.vertex_a_z[31], face.vertex_a_z};
    end
  end

  // Six partial products of the cross product
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_p[0] <= s1_e1[1] * s1_e2[2];
      s2_p[1] <= s1_e1[2] * s1_e2[1];
      s2_p[2] <= s1_e1[2] * s1_e2[0];
      s2_p[3] <= s1_e1[0] * s1_e2[2];
      s2_p[4] <= s1_e1[0] * s1_e2[1];
      s2_p[5] <= s1_e1[1] * s1_e2[0];
    end
  end

  // Cross product components
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < tfn_pkg::NumAxes; i++) begin
        s3_n[i] <= s2_p[2 * i] - s2_p[2 * i + 1];
      end
    end
  end

  // Split into sign and magnitude, flag an all-zero cross product
  always_comb begin
    for (int i = 0; i < tfn_pkg::NumAxes; i++) begin
      abs_n[i] = s3_n[i][65] ? -s3_n[i] : s3_n[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_vld[0] <= 1'b0;
    end else if (adv) begin
      sh_vld[0] <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sh_dgn[0] <= (s3_n[0] == '0) && (s3_n[1] == '0) && (s3_n[2] == '0);
      for (int i = 0; i < tfn_pkg::NumAxes; i++) begin
        sh_neg[0][i] <= s3_n[i][65];
        sh_mag[0][i] <= abs_n[i][64:0];
      end
    end
  end

  // Pre-scale: shift by 32, 16, 8, 4, 2, 1 until all magnitudes fit 31 bits
  for (genvar j = 0; j < tfn_pkg::ShiftSteps; j++) begin : g_shift
    localparam int K = 32 >> j;
    logic [64:0] w;
    logic        big;

    assign w   = sh_mag[j][0] | sh_mag[j][1] | sh_mag[j][2];
    assign big = |(w >> (30 + K));

    always_ff @(posedge clk) begin
      if (rst) begin
        sh_vld[j + 1] <= 1'b0;
      end else if (adv) begin
        sh_vld[j + 1] <= sh_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sh_dgn[j + 1] <= sh_dgn[j];
        sh_neg[j + 1] <= sh_neg[j];
        for (int i = 0; i < tfn_pkg::NumAxes; i++) begin
          sh_mag[j + 1][i] <= big ? (sh_mag[j][i] >> K) : sh_mag[j][i];
        end
      end
    end
  end

  // Square the scaled components
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else if (adv) begin
      sq_vld <= sh_vld[tfn_pkg::ShiftSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_dgn <= sh_dgn[tfn_pkg::ShiftSteps];
      sq_neg <= sh_neg[tfn_pkg::ShiftSteps];
      for (int i = 0; i < tfn_pkg::NumAxes; i++) begin
        sq_m[i] <= sh_mag[tfn_pkg::ShiftSteps][i][30:0];
        sq_v[i] <= {31'b0, sh_mag[tfn_pkg::ShiftSteps][i][30:0]}
                 * {31'b0, sh_mag[tfn_pkg::ShiftSteps][i][30:0]};
      end
    end
  end

  // Sum of squares loads the head of the square root chain
  always_ff @(posedge clk) begin
    if (rst) begin
      sqc[0].tag.vld <= 1'b0;
    end else if (adv) begin
      sqc[0].tag.vld <= sq_vld;
    end
    if (adv) begin
      sqc[0].tag.degen <= sq_dgn;
      sqc[0].tag.neg   <= sq_neg;
      sqc[0].m         <= sq_m;
      sqc[0].rem       <= '0;
      sqc[0].root      <= '0;
      sqc[0].rad       <= {2'b00, sq_v[0]} + {2'b00, sq_v[1]} + {2'b00, sq_v[2]};
    end
  end

  for (genvar k = 0; k < tfn_pkg::SqrtSteps; k++) begin : g_sqrt
    tfn_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .din  (sqc[k]),
      .dout (sqc[k + 1])
    );
  end

  // Dividend m << 31 split into the initial remainder and the bits to come
  always_comb begin
    dvc[0].tag = sqc[tfn_pkg::SqrtSteps].tag;
    dvc[0].len = sqc[tfn_pkg::SqrtSteps].root;
    for (int i = 0; i < tfn_pkg::NumAxes; i++) begin
      dvc[0].rem[i] = {2'b00, sqc[tfn_pkg::SqrtSteps].m[i][30:1]};
      dvc[0].quo[i] = {sqc[tfn_pkg::SqrtSteps].m[i][0], 31'b0};
    end
  end

  for (genvar k = 0; k < tfn_pkg::DivSteps; k++) begin : g_div
    tfn_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .din  (dvc[k]),
      .dout (dvc[k + 1])
    );
  end

  // Round half away from zero from the extra quotient bit, restore the sign
  assign dv_last = dvc[tfn_pkg::DivSteps];

  always_comb begin
    for (int i = 0; i < tfn_pkg::NumAxes; i++) begin
      rnd[i] = {1'b0, dv_last.quo[i]} + 33'd1;
      res[i] = dv_last.tag.neg[i] ? -rnd[i][32:1] : rnd[i][32:1];
      if (dv_last.tag.degen) begin
        res[i] = '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_valid <= 1'b0;
    end else if (adv) begin
      normal_valid <= dv_last.tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      normal.normal_x   <= res[0];
      normal.normal_y   <= res[1];
      normal.normal_z   <= res[2];
      normal.degenerate <= dv_last.tag.degen;
    end
  end

`ifndef SYNTHESIS
  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    normal_valid && normal.degenerate |->
      normal.normal_x == 0 && normal.normal_y == 0 && normal.normal_z == 0)
    else $error("degenerate result with non-zero normal");

  a_unit_range : assert property (@(posedge clk) disable iff (rst)
    normal_valid |->
      normal.normal_x <= 32'sd1073741824 && normal.normal_x >= -32'sd1073741824 &&
      normal.normal_y <= 32'sd1073741824 && normal.normal_y >= -32'sd1073741824 &&
      normal.normal_z <= 32'sd1073741824 && normal.normal_z >= -32'sd1073741824)
    else $error("normal component outside unit range");

  a_reset_empty : assert property (@(posedge clk)
    !rst && $past(rst) |-> !normal_valid)
    else $error("result presented straight after reset");
`endif

endmodule

[design/tfn_sqrt_cell.sv]
// One cell of the integer square root chain: settles one root bit.
// Depends on tfn_pkg for the stage struct.
module tfn_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  tfn_pkg::sqrt_stage_t din,
  output tfn_pkg::sqrt_stage_t dout
);

  logic                 vld;
  tfn_pkg::sqrt_stage_t pay;
  tfn_pkg::sqrt_stage_t pay_next;
  logic [35:0]          cur;
  logic [35:0]          trial;
  logic [35:0]          diff;
  logic                 ge;

  // Bring in the next two radicand bits and try the next root bit
  always_comb begin
    cur   = {din.rem, din.rad[63:62]};
    trial = {2'b00, din.root, 2'b01};
    ge    = (cur >= trial);
    diff  = cur - trial;
    pay_next      = din;
    pay_next.rem  = ge ? diff[33:0] : cur[33:0];
    pay_next.root = {din.root[30:0], ge};
    pay_next.rad  = {din.rad[61:0], 2'b00};
  end

  // Clear the valid flag under reset, advance with the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= din.tag.vld;
    end
  end

  // Advance remainder, root and radicand
  always_ff @(posedge clk) begin
    if (adv) begin
      pay <= pay_next;
    end
  end

  always_comb begin
    dout         = pay;
    dout.tag.vld = vld;
  end

endmodule

[design/tfn_div_cell.sv]
// One cell of the restoring division chain: one quotient bit per lane.
// Depends on tfn_pkg for the stage struct.
module tfn_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  tfn_pkg::div_stage_t din,
  output tfn_pkg::div_stage_t dout
);

  logic                vld;
  tfn_pkg::div_stage_t pay;
  tfn_pkg::div_stage_t pay_next;
  logic [2:0][32:0]    cur;
  logic [2:0][32:0]    diff;
  logic [2:0]          ge;

  // Shift in the next dividend bit and compare against the length
  always_comb begin
    pay_next = din;
    for (int i = 0; i < tfn_pkg::NumAxes; i++) begin
      cur[i]  = {din.rem[i], din.quo[i][31]};
      ge[i]   = (cur[i] >= {1'b0, din.len});
      diff[i] = cur[i] - {1'b0, din.len};
      pay_next.rem[i] = ge[i] ? diff[i][31:0] : cur[i][31:0];
      pay_next.quo[i] = {din.quo[i][30:0], ge[i]};
    end
  end

  // Clear the valid flag under reset, advance with the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= din.tag.vld;
    end
  end

  // Advance partial remainders and quotients
  always_ff @(posedge clk) begin
    if (adv) begin
      pay <= pay_next;
    end
  end

  always_comb begin
    dout         = pay;
    dout.tag.vld = vld;
  end

endmodule
